// ===== hdl/sxfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sxfd_pkg
// Shared types and constants of the sync/XOR frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sxfd_pkg;

    localparam int unsigned DATA_BYTES_DEF = 12;
    localparam int unsigned STORE_MAX      = 12;
    localparam int unsigned NUM_CHANNELS   = 6;
    localparam int unsigned COUNT_W        = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_GOOD   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_TEXT   = 2'd2
    } kind_t;

endpackage

`default_nettype wire

// ===== hdl/sync_xor_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_xor_frame_deframer_unit
// Hunts for the 0xAA 0x55 sync pair, collects the data bytes and the XOR
// check byte, and emits a good frame, a reject, or a text-path byte.
// ----------------------------------------------------------------------------
// A result is registered and is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; input stalls only while a held result is
// stalled downstream, whether or not the next byte makes a result.
// A result accepted downstream frees the register in the same cycle.
// Reset clears phase, byte count, running XOR and the output valid flag;
// the frame store holds no reset value.
`default_nettype none

module sync_xor_frame_deframer_unit #(
    parameter int unsigned DATA_BYTES = sxfd_pkg::DATA_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       text_byte,
    output logic [15:0]      chan_a,
    output logic [15:0]      chan_b,
    output logic [15:0]      chan_c,
    output logic [15:0]      chan_d,
    output logic [15:0]      chan_e,
    output logic [15:0]      chan_f
);

    localparam logic [sxfd_pkg::COUNT_W-1:0] LAST_COUNT =
        sxfd_pkg::COUNT_W'(DATA_BYTES);

    sxfd_pkg::phase_t                phase_reg, phase_next;
    logic [sxfd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [7:0]                      xor_reg, xor_next;
    logic [7:0]                      store_reg [DATA_BYTES];
    logic [7:0]                      frame_byte [sxfd_pkg::STORE_MAX];

    logic                            in_accept;
    logic                            out_accept;
    logic                            res_fire;
    sxfd_pkg::kind_t                 res_kind;
    logic [7:0]                      res_text;
    logic                            store_en;

    logic                            out_valid_reg;
    sxfd_pkg::kind_t                 kind_reg;
    logic [7:0]                      text_reg;
    logic [15:0]                     chan_reg [sxfd_pkg::NUM_CHANNELS];

    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        store_en   = 1'b0;
        unique case (phase_reg)
            sxfd_pkg::PH_FRAME:
            begin
                if (count_reg < LAST_COUNT)
                begin
                    store_en   = 1'b1;
                    xor_next   = xor_reg ^ rx_byte;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    phase_next = sxfd_pkg::PH_HUNT1;
                    count_next = '0;
                    xor_next   = '0;
                end
            end
            sxfd_pkg::PH_HUNT2:
            begin
                if (rx_byte == sxfd_pkg::SYNC_SECOND)
                begin
                    phase_next = sxfd_pkg::PH_FRAME;
                    count_next = '0;
                    xor_next   = '0;
                end
                else
                begin
                    phase_next = sxfd_pkg::PH_HUNT1;
                end
            end
            default:
            begin
                if (rx_byte == sxfd_pkg::SYNC_FIRST)
                begin
                    phase_next = sxfd_pkg::PH_HUNT2;
                end
                else
                begin
                    phase_next = sxfd_pkg::PH_HUNT1;
                end
            end
        endcase
    end

    // result
    always_comb
    begin
        res_fire = 1'b0;
        res_kind = sxfd_pkg::KIND_TEXT;
        res_text = rx_byte;
        unique case (phase_reg)
            sxfd_pkg::PH_FRAME:
            begin
                res_text = '0;
                if (count_reg >= LAST_COUNT)
                begin
                    res_fire = 1'b1;
                    res_kind = (xor_reg == rx_byte) ? sxfd_pkg::KIND_GOOD
                                                    : sxfd_pkg::KIND_REJECT;
                end
            end
            sxfd_pkg::PH_HUNT2:
            begin
                res_fire = (rx_byte != sxfd_pkg::SYNC_SECOND);
            end
            default:
            begin
                res_fire = (rx_byte != sxfd_pkg::SYNC_FIRST);
            end
        endcase
    end

    for (genvar i = 0; i < sxfd_pkg::STORE_MAX; i++)
    begin : g_bytes
        if (i < DATA_BYTES)
        begin : g_live
            always_ff @(posedge clk)
            begin
                if (in_accept && store_en &&
                    count_reg == sxfd_pkg::COUNT_W'(i))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
            assign frame_byte[i] = store_reg[i];
        end
        else
        begin : g_zero
            assign frame_byte[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sxfd_pkg::PH_HUNT1;
            count_reg     <= '0;
            xor_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                xor_reg   <= xor_next;
            end
            if (in_accept && res_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && res_fire)
        begin
            kind_reg <= res_kind;
            text_reg <= res_text;
            for (int k = 0; k < sxfd_pkg::NUM_CHANNELS; k++)
            begin
                chan_reg[k] <= (res_kind == sxfd_pkg::KIND_GOOD)
                             ? {frame_byte[2*k+1], frame_byte[2*k]} : 16'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign text_byte = text_reg;
    assign chan_a    = chan_reg[0];
    assign chan_b    = chan_reg[1];
    assign chan_c    = chan_reg[2];
    assign chan_d    = chan_reg[3];
    assign chan_e    = chan_reg[4];
    assign chan_f    = chan_reg[5];

endmodule

`default_nettype wire

// ===== verif/sync_xor_frame_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_xor_frame_deframer_unit_tb
// Feeds byte streams of text, lone and doubled sync bytes, good frames and
// frames with a bad check byte into the deframer. Random idle bursts fall on
// both channels. A local model of the hunt/collect/check logic predicts every
// transaction out, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module sync_xor_frame_deframer_unit_tb;

    localparam int unsigned FRAME_LEN   = sxfd_pkg::DATA_BYTES_DEF;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        sxfd_pkg::kind_t                         kind;
        logic [7:0]                              text;
        logic [sxfd_pkg::NUM_CHANNELS-1:0][15:0] chan;
    } deframe_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [15:0] chan_a, chan_b, chan_c, chan_d, chan_e, chan_f;

    sxfd_pkg::phase_t frame_phase = sxfd_pkg::PH_HUNT1;
    logic [3:0]  frame_count = '0;
    logic [7:0]  frame_xor   = '0;
    logic [7:0]  frame_bytes [sxfd_pkg::STORE_MAX];

    deframe_result_t pending_results [$];
    bit          idle_on        = 1'b1;
    int          items_sent     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;

    sync_xor_frame_deframer_unit #(
        .DATA_BYTES(FRAME_LEN)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .text_byte(text_byte),
        .chan_a   (chan_a),
        .chan_b   (chan_b),
        .chan_c   (chan_c),
        .chan_d   (chan_d),
        .chan_e   (chan_e),
        .chan_f   (chan_f)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        logic [7:0]      lo, hi;
        begin
            r = '0;
            if (frame_phase == sxfd_pkg::PH_FRAME)
            begin
                if (int'(frame_count) < FRAME_LEN)
                begin
                    if (frame_count < sxfd_pkg::STORE_MAX)
                        frame_bytes[frame_count] = b;
                    frame_xor   = frame_xor ^ b;
                    frame_count = frame_count + 4'd1;
                end
                else
                begin
                    if (frame_xor == b)
                    begin
                        r.kind = sxfd_pkg::KIND_GOOD;
                        for (int k = 0; k < sxfd_pkg::NUM_CHANNELS; k++)
                        begin
                            lo = (2 * k < FRAME_LEN) ? frame_bytes[2 * k] : 8'h00;
                            hi = (2 * k + 1 < FRAME_LEN) ? frame_bytes[2 * k + 1] : 8'h00;
                            r.chan[k] = {hi, lo};
                        end
                    end
                    else
                    begin
                        r.kind = sxfd_pkg::KIND_REJECT;
                    end
                    frame_phase = sxfd_pkg::PH_HUNT1;
                    frame_count = '0;
                    frame_xor   = '0;
                    pending_results.push_back(r);
                end
            end
            else if (frame_phase == sxfd_pkg::PH_HUNT2 && b == sxfd_pkg::SYNC_SECOND)
            begin
                frame_phase = sxfd_pkg::PH_FRAME;
                frame_count = '0;
                frame_xor   = '0;
            end
            else if (frame_phase != sxfd_pkg::PH_HUNT2 && b == sxfd_pkg::SYNC_FIRST)
            begin
                frame_phase = sxfd_pkg::PH_HUNT2;
            end
            else
            begin
                frame_phase = sxfd_pkg::PH_HUNT1;
                r.kind      = sxfd_pkg::KIND_TEXT;
                r.text      = b;
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        deframe_result_t want;
        logic [sxfd_pkg::NUM_CHANNELS-1:0][15:0] got_chan;
        if (rst_n && out_valid && !out_stall)
        begin
            got_chan = {chan_f, chan_e, chan_d, chan_c, chan_b, chan_a};
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected transaction kind", 16'h0, {14'h0, kind});
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    note_mismatch("kind", {14'h0, want.kind}, {14'h0, kind});
                if (text_byte !== want.text)
                    note_mismatch("text_byte", {8'h0, want.text}, {8'h0, text_byte});
                for (int k = 0; k < sxfd_pkg::NUM_CHANNELS; k++)
                    if (got_chan[k] !== want.chan[k])
                        note_mismatch($sformatf("channel %0d", k), want.chan[k],
                                      got_chan[k]);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                rx_byte  <= 8'($urandom);
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte  <= b;
            do
                @(posedge clk);
            while (in_stall);
            deframe_byte(b);
            items_sent++;
        end
    endtask

    task automatic send_frame(input logic [FRAME_LEN-1:0][7:0] data, input bit corrupt);
        logic [7:0] check;
        begin
            check = '0;
            send_byte(sxfd_pkg::SYNC_FIRST);
            send_byte(sxfd_pkg::SYNC_SECOND);
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                send_byte(data[i]);
                check = check ^ data[i];
            end
            if (corrupt)
                check = check ^ 8'($urandom_range(1, 255));
            send_byte(check);
        end
    endtask

    task automatic random_frame(input bit corrupt);
        logic [FRAME_LEN-1:0][7:0] data;
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    data[i] = $urandom_range(0, 1) ? sxfd_pkg::SYNC_FIRST
                                                   : sxfd_pkg::SYNC_SECOND;
                else
                    data[i] = 8'($urandom);
            end
            send_frame(data, corrupt);
        end
    endtask

    task automatic test_text_bytes();
        begin
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(sxfd_pkg::SYNC_SECOND);
        end
    endtask

    task automatic test_lone_sync();
        begin
            send_byte(sxfd_pkg::SYNC_FIRST);
            send_byte(8'h7F);
            send_byte(sxfd_pkg::SYNC_FIRST);
            send_byte(sxfd_pkg::SYNC_FIRST);
        end
    endtask

    task automatic test_good_frame();
        begin
            send_frame({8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFE, 8'h7F,
                        8'h80, 8'h01, 8'h55, 8'hAA, 8'h00, 8'hFF}, 1'b0);
        end
    endtask

    task automatic test_bad_check();
        begin
            send_frame({8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                        8'h40, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h00}, 1'b1);
        end
    endtask

    task automatic test_random_stream(input int count);
        int start;
        int pick;
        begin
            start = items_sent;
            while (items_sent - start < count)
            begin
                if ($urandom_range(0, 9) == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 9);
                if (pick <= 6)
                begin
                    random_frame($urandom_range(0, 5) == 0);
                end
                else if (pick == 7)
                begin
                    send_byte(sxfd_pkg::SYNC_FIRST);
                    send_byte(sxfd_pkg::SYNC_SECOND);
                    repeat ($urandom_range(0, FRAME_LEN)) send_byte(8'($urandom));
                end
                else if (pick == 8)
                begin
                    send_byte(sxfd_pkg::SYNC_FIRST);
                    send_byte($urandom_range(0, 1) ? sxfd_pkg::SYNC_FIRST : 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
        end
    endtask

    task automatic test_drain_pause();
        begin
            idle_on = 1'b1;
            random_frame(1'b0);
            send_byte(8'h3C);
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            random_frame(1'b0);
        end
    endtask

    task automatic test_tail_no_idle();
        begin
            idle_on = 1'b0;
            random_frame(1'b0);
            random_frame(1'b1);
            send_byte(sxfd_pkg::SYNC_FIRST);
            send_byte(8'h12);
            repeat (8) send_byte(8'($urandom));
            random_frame(1'b0);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_text_bytes();
        test_lone_sync();
        test_good_frame();
        test_bad_check();
        test_random_stream(380);
        test_drain_pause();
        test_random_stream(380);
        test_tail_no_idle();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
